>>> sv/stb_pkg.sv
package stb_pkg;

	localparam int NUM_TIMERS_DEF  = 8;
	localparam int COUNT_WIDTH_DEF = 32;

	// Fixed field widths of the stream payload.
	localparam int KIND_W   = 3;
	localparam int INDEX_W  = 3;
	localparam int VALUE_W  = 32;
	localparam int OUT_W    = 32;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK       = 3'd0,
		KIND_CONFIG     = 3'd1,
		KIND_SET_RELOAD = 3'd2,
		KIND_RESTART    = 3'd3,
		KIND_QUERY      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_WRITE,
		ST_RESP
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic               count_up;
		logic               enable_on;
	} cmd_t;

endpackage

>>> sv/stb_ram.sv
module stb_ram #(
	parameter int WIDTH = 67,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/stb_timer_alu.sv
module stb_timer_alu import stb_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  cmd_t                   cmd,
	input  logic                   old_mode_up,
	input  logic                   old_running,
	input  logic                   old_ran_out,
	input  logic [COUNT_WIDTH-1:0] old_reload,
	input  logic [COUNT_WIDTH-1:0] old_count,
	output logic                   new_mode_up,
	output logic                   new_running,
	output logic                   new_ran_out,
	output logic [COUNT_WIDTH-1:0] new_reload,
	output logic [COUNT_WIDTH-1:0] new_count,
	output logic                   flag,
	output logic [OUT_W-1:0]       count_now
);

	logic [COUNT_WIDTH+VALUE_W-1:0] val_ext;
	logic [COUNT_WIDTH+OUT_W-1:0]   cnt_ext;
	logic [COUNT_WIDTH-1:0]         val;
	logic [COUNT_WIDTH-1:0]         inc;
	logic [COUNT_WIDTH-1:0]         dec;

	// The value field is cut down to, or zero-extended to, the counter width before it is stored.
	assign val_ext   = {{COUNT_WIDTH{1'b0}}, cmd.value};
	assign val       = val_ext[COUNT_WIDTH-1:0];
	assign inc       = old_count + COUNT_WIDTH'(1);
	assign dec       = old_count - COUNT_WIDTH'(1);
	assign cnt_ext   = {{OUT_W{1'b0}}, new_count};
	assign count_now = cnt_ext[OUT_W-1:0];

	always_comb begin
		new_mode_up = old_mode_up;
		new_running = old_running;
		new_ran_out = old_ran_out;
		new_reload  = old_reload;
		new_count   = old_count;
		flag        = 1'b0;
		unique case (cmd.kind)
			KIND_TICK: begin
				if (old_running) begin
					if (old_mode_up) begin
						new_count = inc;
						if (old_reload != '0 && inc == old_reload) begin
							new_ran_out = 1'b1;
						end
					end else if (old_count != '0) begin
						// A down timer that runs out reloads in the same step.
						if (dec == '0) begin
							new_ran_out = 1'b1;
							new_count   = old_reload;
						end else begin
							new_count = dec;
						end
					end
				end
			end
			KIND_CONFIG: begin
				new_reload  = val;
				new_mode_up = cmd.count_up;
				new_running = cmd.enable_on;
				new_ran_out = 1'b0;
				new_count   = cmd.count_up ? '0 : val;
			end
			KIND_SET_RELOAD: begin
				new_reload = val;
			end
			KIND_RESTART: begin
				new_count   = old_mode_up ? '0 : old_reload;
				new_ran_out = 1'b0;
				new_running = 1'b1;
			end
			KIND_QUERY: begin
				flag        = old_ran_out;
				new_ran_out = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/software_timer_bank.sv
// Channel  Direction  Signals                          Contents
// s_axis   in         s_tvalid s_tready s_tdata s_tuser timer commands
// m_axis   out        m_tvalid m_tready m_tdata         one result per command
//
// A tick walks the timer memory one entry per cycle, reading the next entry
// while the current one is written back, and then gives its result.
// Configure, set reload, restart and query go through read, write and result steps;
// a command for an unknown kind or a missing timer goes straight to the result step.
// Reset clears all timers at once through per-entry valid bits; no sweep is needed.
// A stalled output holds one result while the next command is already taken.
module software_timer_bank import stb_pkg::*; #(
	parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// timer_index[2:0], value[34:3], count_up[35], enable_on[36], zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	// kind[2:0]
	input  logic [KIND_W-1:0]   s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// elapsed[0], count_now[32:1], zero fill
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int EW = 2 * COUNT_WIDTH + 3;

	state_t                 state_q;
	state_t                 state_d;
	kind_t                  in_kind;
	logic [INDEX_W-1:0]     in_idx;
	logic [6:0]             in_idx_ext;
	logic                   in_known;
	logic                   in_hit;
	logic [IW-1:0]          in_addr;
	cmd_t                   in_cmd;
	cmd_t                   cmd_q;
	logic [IW-1:0]          ptr_q;
	logic [NUM_TIMERS-1:0]  valid_q;
	logic                   vld_s1;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   wr_en;
	logic [EW-1:0]          ram_rdata;
	logic [EW-1:0]          rd_entry;
	logic [EW-1:0]          wr_entry;
	logic                   res_flag_q;
	logic [OUT_W-1:0]       res_count_q;
	logic                   m_tvalid_q;
	logic [M_DATA_W-1:0]    m_tdata_q;
	logic                   out_load;
	logic                   alu_mode_up;
	logic                   alu_running;
	logic                   alu_ran_out;
	logic [COUNT_WIDTH-1:0] alu_reload;
	logic [COUNT_WIDTH-1:0] alu_count;
	logic                   alu_flag;
	logic [OUT_W-1:0]       alu_count_now;

	assign in_kind    = kind_t'(s_tuser);
	assign in_idx     = s_tdata[2:0];
	assign in_idx_ext = {4'b0, in_idx};
	assign in_addr    = in_idx_ext[IW-1:0];
	assign in_cmd     = '{kind: in_kind, value: s_tdata[34:3],
		count_up: s_tdata[35], enable_on: s_tdata[36]};

	always_comb begin
		unique case (in_kind)
			KIND_CONFIG, KIND_SET_RELOAD, KIND_RESTART, KIND_QUERY: in_known = 1'b1;
			default: in_known = 1'b0;
		endcase
	end

	assign in_hit = in_known && (in_idx_ext < 7'(NUM_TIMERS));

	assign out_load = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = ptr_q;
		wr_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_kind == KIND_TICK) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_TICK;
					end else if (in_hit) begin
						rd_en   = 1'b1;
						rd_addr = in_addr;
						state_d = ST_WRITE;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_TICK: begin
				wr_en = 1'b1;
				if (ptr_q == IW'(NUM_TIMERS - 1)) begin
					state_d = ST_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + IW'(1);
				end
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// An entry that was never written since reset reads as all zeros.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[ptr_q] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ptr_q  <= rd_addr;
			vld_s1 <= valid_q[rd_addr];
		end
		if (s_tvalid && s_tready) begin
			cmd_q       <= in_cmd;
			res_flag_q  <= 1'b0;
			res_count_q <= '0;
		end
		if (state_q == ST_WRITE) begin
			res_flag_q  <= alu_flag;
			res_count_q <= alu_count_now;
		end
		if (out_load) begin
			m_tdata_q <= {{(M_DATA_W - OUT_W - 1){1'b0}}, res_count_q, res_flag_q};
		end
	end

	assign rd_entry = vld_s1 ? ram_rdata : '0;

	stb_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ptr_q),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	stb_timer_alu #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_alu (
		.cmd        (cmd_q),
		.old_mode_up(rd_entry[2*COUNT_WIDTH+2]),
		.old_running(rd_entry[2*COUNT_WIDTH+1]),
		.old_ran_out(rd_entry[2*COUNT_WIDTH]),
		.old_reload (rd_entry[2*COUNT_WIDTH-1:COUNT_WIDTH]),
		.old_count  (rd_entry[COUNT_WIDTH-1:0]),
		.new_mode_up(alu_mode_up),
		.new_running(alu_running),
		.new_ran_out(alu_ran_out),
		.new_reload (alu_reload),
		.new_count  (alu_count),
		.flag       (alu_flag),
		.count_now  (alu_count_now)
	);

	assign wr_entry = {alu_mode_up, alu_running, alu_ran_out, alu_reload, alu_count};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
